FILE: rtl/core/atdsc_pkg.sv
// ----------------------------------------------------------------------------
// atdsc_pkg
// Shared types and constants of the angle to detent step counter: field
// widths, command and register codes, and the channel and queue entry structs.
// ----------------------------------------------------------------------------
package atdsc_pkg;

   localparam int ANGLE_W         = 12;
   localparam int COUNTS_PER_TURN = 4096;
   localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
   localparam int DEFAULT_DETENTS = 24;
   localparam int STEP_MULT       = 8;
   localparam int MIN_STEPS       = 24;
   localparam int MAX_STEPS       = 1024;
   localparam int DETENT_W        = 8;
   localparam int SPT_W           = 11;
   localparam int DIFF_W          = ANGLE_W + 2;
   localparam int DELTA_W         = ANGLE_W + 1;
   localparam int PROD_W          = DELTA_W + SPT_W + 1;
   localparam int SUM_W           = PROD_W + 1;
   localparam int REM_BITS        = $clog2(COUNTS_PER_TURN);
   localparam int REM_W           = REM_BITS + 1;
   localparam int STEPS_W         = 11;
   localparam int COUNT_W         = 32;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 8;
   localparam int QUEUE_DEPTH_DEF = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DETENT_COUNT     = 1'b0,
      CSR_INVERT_DIRECTION = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE  = 1'b0,
      CMD_CONSUME = 1'b1
   } command_type;

   typedef enum logic {
      OP_STEP    = 1'b0,
      OP_CONSUME = 1'b1
   } op_code_type;

   typedef struct packed {
      logic               command;
      logic [ANGLE_W-1:0] raw_angle;
   } req_type;

   typedef struct packed {
      logic signed [STEPS_W-1:0] steps_emitted;
      logic signed [COUNT_W-1:0] taken_delta;
      logic signed [COUNT_W-1:0] position_count;
   } rsp_type;

   typedef struct packed {
      logic [DETENT_W-1:0] detent_count;
      logic                invert_direction;
   } cfg_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      op_code_type              op;
      logic signed [PROD_W-1:0] product;
   } op_type;

   // Detents times eight, with zero meaning the default, held to the legal range.
   function automatic logic [SPT_W-1:0] steps_per_turn(input logic [DETENT_W-1:0] detents);
      logic [DETENT_W-1:0] base;
      logic [SPT_W-1:0]    spt;
      base = (detents != '0) ? detents : DETENT_W'(DEFAULT_DETENTS);
      spt  = SPT_W'(base) * SPT_W'(STEP_MULT);
      if (spt < SPT_W'(MIN_STEPS)) begin
         spt = SPT_W'(MIN_STEPS);
      end
      if (spt > SPT_W'(MAX_STEPS)) begin
         spt = SPT_W'(MAX_STEPS);
      end
      return spt;
   endfunction

endpackage

FILE: rtl/core/atdsc_front.sv
// ----------------------------------------------------------------------------
// atdsc_front
// Accepts request items, classifies them, forms the wrap-corrected angle
// delta and scales it by the steps per turn before handing it to the queue.
// ----------------------------------------------------------------------------
module atdsc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  atdsc_pkg::req_type req_data,
   input  atdsc_pkg::cfg_type cfg,
   input  logic               queue_full,
   output logic               push,
   output atdsc_pkg::op_type  push_op
);
   import atdsc_pkg::*;

   localparam logic signed [DIFF_W-1:0] TURN_D = DIFF_W'(COUNTS_PER_TURN);
   localparam logic signed [DIFF_W-1:0] HALF_D = DIFF_W'(HALF_TURN);

   logic [ANGLE_W-1:0]         last_angle_ff;
   logic [ANGLE_W-1:0]         last_angle_in;
   logic                       primed_ff;
   logic                       primed_in;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [DIFF_W-1:0]   wrapped;
   logic signed [DELTA_W-1:0]  delta;
   logic [SPT_W-1:0]           spt;
   logic signed [PROD_W-1:0]   product;
   logic                       accept;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;
   assign push      = accept;

   always_comb begin
      diff = $signed({2'b00, req_data.raw_angle}) - $signed({2'b00, last_angle_ff});
      if (diff > HALF_D) begin
         wrapped = diff - TURN_D;
      end else if (diff < -HALF_D) begin
         wrapped = diff + TURN_D;
      end else begin
         wrapped = diff;
      end
      delta   = wrapped[DELTA_W-1:0];
      spt     = steps_per_turn(cfg.detent_count);
      product = PROD_W'(delta) * PROD_W'($signed({1'b0, spt}));
   end

   always_comb begin
      last_angle_in   = last_angle_ff;
      primed_in       = primed_ff;
      push_op.op      = OP_STEP;
      push_op.product = '0;
      if (req_data.command == CMD_CONSUME) begin
         push_op.op = OP_CONSUME;
      end else if (!primed_ff) begin
         // The priming sample passes through as a step of zero.
         last_angle_in = req_data.raw_angle;
         primed_in     = 1'b1;
      end else begin
         last_angle_in   = req_data.raw_angle;
         push_op.product = cfg.invert_direction ? -product : product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else if (accept) begin
         primed_ff <= primed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
      end else if (accept) begin
         last_angle_ff <= last_angle_in;
      end
   end

endmodule

FILE: rtl/core/atdsc_queue.sv
// ----------------------------------------------------------------------------
// atdsc_queue
// Small first-in first-out queue of classified items between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module atdsc_queue #(
   parameter int DEPTH = atdsc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  atdsc_pkg::op_type push_op,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output atdsc_pkg::op_type head_op
);
   import atdsc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type           entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: rtl/core/atdsc_back.sv
// ----------------------------------------------------------------------------
// atdsc_back
// Carries out queued items: adds the scaled delta to the step remainder,
// takes out whole turns as steps, keeps the pending and position counters
// and holds the result register.
// ----------------------------------------------------------------------------
module atdsc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  atdsc_pkg::op_type  head_op,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output atdsc_pkg::rsp_type rsp_data
);
   import atdsc_pkg::*;

   logic signed [REM_W-1:0]   remainder_ff;
   logic signed [REM_W-1:0]   remainder_in;
   logic [COUNT_W-1:0]        pending_ff;
   logic [COUNT_W-1:0]        pending_in;
   logic [COUNT_W-1:0]        position_ff;
   logic [COUNT_W-1:0]        position_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_type                   rsp_data_ff;
   rsp_type                   rsp_data_in;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   quo_floor;
   logic [REM_BITS-1:0]       frac;
   logic                      round_up;
   logic signed [STEPS_W-1:0] emitted;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pop       = head_valid & (~rsp_valid_ff | ~rsp_stall);

   // The shift floors; a negative sum with a fraction is moved back toward zero.
   always_comb begin
      sum       = SUM_W'(head_op.product) + SUM_W'(remainder_ff);
      quo_floor = sum >>> REM_BITS;
      frac      = sum[REM_BITS-1:0];
      round_up  = sum[SUM_W-1] & (frac != '0);
      emitted   = round_up ? STEPS_W'(quo_floor) + 1'b1 : STEPS_W'(quo_floor);
   end

   always_comb begin
      remainder_in = remainder_ff;
      pending_in   = pending_ff;
      position_in  = position_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         if (head_op.op == OP_CONSUME) begin
            pending_in                 = '0;
            rsp_data_in.steps_emitted  = '0;
            rsp_data_in.taken_delta    = pending_ff;
            rsp_data_in.position_count = position_ff;
         end else begin
            remainder_in               = {round_up, frac};
            pending_in                 = pending_ff + COUNT_W'(emitted);
            position_in                = position_ff + COUNT_W'(emitted);
            rsp_data_in.steps_emitted  = emitted;
            rsp_data_in.taken_delta    = '0;
            rsp_data_in.position_count = position_in;
         end
      end
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remainder_ff <= '0;
         pending_ff   <= '0;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         remainder_ff <= remainder_in;
         pending_ff   <= pending_in;
         position_ff  <= position_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/core/angle_to_detent_step_counter.sv
// ----------------------------------------------------------------------------
// angle_to_detent_step_counter
// Turns absolute shaft-angle samples into signed detent steps and keeps a
// pending step delta and a running position.
// ----------------------------------------------------------------------------
// Usage:
// Each request transfer carries a command and a 12-bit raw angle. A sample
// (command 0) yields the steps it produced; a consume (command 1) returns
// the pending step delta and clears it. Every request gives exactly one
// response transfer, in order, carrying the position after that item.
// The first sample after reset only primes the angle register.
// The front's wrap and scale logic writes the queue at the request transfer
// edge, and the back's remainder update then loads the result register from
// the queue head and raises response valid. Throughput is one item per cycle
// while the receiver does not stall, set by the remainder loop in the back.
// When the receiver stalls, the result register holds and the queue
// (QUEUE_DEPTH entries) fills; req_stall rises once the queue is full.
// Reset sets detent_count to 24, invert_direction to 0 and clears all counts.
// Configuration is written through csr_write_en, csr_index and csr_wdata
// while no item is in flight.
// ----------------------------------------------------------------------------
module angle_to_detent_step_counter #(
   parameter int QUEUE_DEPTH = atdsc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  atdsc_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output atdsc_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_write_en,
   input  logic [atdsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [atdsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import atdsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    q_push;
   op_type  q_push_op;
   logic    q_full;
   logic    q_valid;
   op_type  q_head;
   logic    q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DETENT_COUNT: begin
               cfg_in.detent_count = csr_wdata[DETENT_W-1:0];
            end
            CSR_INVERT_DIRECTION: begin
               cfg_in.invert_direction = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detent_count     <= DETENT_W'(DEFAULT_DETENTS);
         cfg_ff.invert_direction <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   atdsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (q_full),
      .push       (q_push),
      .push_op    (q_push_op)
   );

   atdsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_push_op),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_op    (q_head)
   );

   atdsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_op    (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // A consume never reports steps, so a nonzero returned delta implies zero steps.
   a_consume_no_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.taken_delta != '0) |-> (rsp_data.steps_emitted == '0))
      else $error("nonzero taken delta together with emitted steps");

   // An accepted request must be waiting in the queue in the next cycle.
   a_accept_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> q_valid)
      else $error("accepted request did not reach the queue");

   // A new result appears only after the back took an item from the queue.
   a_result_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop))
      else $error("result appeared without a queue pop");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the angle to detent step counter. A scoreboard
// class tracks the angle, remainder and step counters of the block, predicts
// every response in order and compares it field by field. Directed items
// cover wrap-around, half-turn deltas, priming and the largest step counts;
// random encoder motion with consumes follows under several register settings,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import atdsc_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 200;

   class detent_step_scoreboard;
      rsp_type             awaited_counts[$];
      logic [DETENT_W-1:0] detents;
      logic                invert;
      logic [ANGLE_W-1:0]  last_angle;
      bit                  primed;
      int                  remainder;
      logic [COUNT_W-1:0]  pending;
      logic [COUNT_W-1:0]  position;
      int                  failures;

      function new();
         detents    = 8'd24;
         invert     = 1'b0;
         last_angle = '0;
         primed     = 1'b0;
         remainder  = 0;
         pending    = '0;
         position   = '0;
         failures   = 0;
      endfunction

      function void set_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_DETENT_COUNT) begin
            detents = value;
         end else begin
            invert = value[0];
         end
      endfunction

      function void predict_counts(req_type item);
         int      delta;
         int      spt;
         int      total;
         int      emitted;
         rsp_type want;
         want = '0;
         if (item.command == CMD_CONSUME) begin
            want.taken_delta = pending;
            pending = '0;
         end else if (!primed) begin
            last_angle = item.raw_angle;
            primed     = 1'b1;
         end else begin
            delta = int'(item.raw_angle) - int'(last_angle);
            if (delta > COUNTS_PER_TURN / 2) begin
               delta -= COUNTS_PER_TURN;
            end else if (delta < -(COUNTS_PER_TURN / 2)) begin
               delta += COUNTS_PER_TURN;
            end
            last_angle = item.raw_angle;
            spt = (detents != 0) ? int'(detents) * STEP_MULT : DEFAULT_DETENTS * STEP_MULT;
            if (spt < MIN_STEPS) begin
               spt = MIN_STEPS;
            end
            if (spt > MAX_STEPS) begin
               spt = MAX_STEPS;
            end
            total = delta * spt;
            if (invert) begin
               total = -total;
            end
            total += remainder;
            // Signed division truncates toward zero, as the block does.
            emitted   = total / COUNTS_PER_TURN;
            remainder = total - emitted * COUNTS_PER_TURN;
            pending  += COUNT_W'(emitted);
            position += COUNT_W'(emitted);
            want.steps_emitted = STEPS_W'(emitted);
         end
         want.position_count = position;
         awaited_counts.push_back(want);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         failures++;
      endtask

      task check_counts(rsp_type got);
         rsp_type want;
         if (awaited_counts.size() == 0) begin
            report("response transfer with no response expected");
         end else begin
            want = awaited_counts.pop_front();
            if (got.steps_emitted !== want.steps_emitted) begin
               report($sformatf("steps_emitted %0d, expected %0d",
                                got.steps_emitted, want.steps_emitted));
            end
            if (got.taken_delta !== want.taken_delta) begin
               report($sformatf("taken_delta %0d, expected %0d",
                                got.taken_delta, want.taken_delta));
            end
            if (got.position_count !== want.position_count) begin
               report($sformatf("position_count %0d, expected %0d",
                                got.position_count, want.position_count));
            end
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   detent_step_scoreboard board = new();
   bit                    quiet = 1'b0;
   bit                    hold_off_pending = 1'b0;
   logic [ANGLE_W-1:0]    walk_angle = '0;
   int                    cycles = 0;

   angle_to_detent_step_counter dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.predict_counts(req_data);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_counts(rsp_data);
      end
   end

   // Receiver: random stalls, none while quiet, and one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 28);
         end
      end
   end

   // Offers one item, at times after a random gap, and returns at the edge of its transfer.
   task automatic send_item(input req_type item);
      if (!quiet && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.awaited_counts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.set_register(index, value);
   endtask

   function automatic req_type make_item(command_type command, int angle);
      req_type item;
      item.command   = command;
      item.raw_angle = ANGLE_W'(angle);
      return item;
   endfunction

   task automatic run_phase(input logic [DETENT_W-1:0] detents, input logic invert,
                            input int count, input int quiet_items, input int hold_at);
      req_type item;
      int      pick;
      int      jump;
      write_register(CSR_DETENT_COUNT, detents);
      write_register(CSR_INVERT_DIRECTION, {7'($urandom_range(0, 127)), invert});
      for (int i = 0; i < count; i++) begin
         quiet = (i < quiet_items);
         if (i == hold_at) begin
            hold_off_pending = 1'b1;
         end
         pick = $urandom_range(0, 99);
         item = make_item(CMD_SAMPLE, $urandom_range(0, 4095));
         if (pick < 10) begin
            item.command = CMD_CONSUME;
         end else begin
            if (pick < 20) begin
               walk_angle = item.raw_angle;
            end else if (pick < 28) begin
               // Jumps around half a turn exercise the wrap correction edges.
               walk_angle = walk_angle + ANGLE_W'($urandom_range(2047, 2049));
            end else begin
               jump = (pick < 88) ? int'($urandom_range(0, 400)) - 200
                                  : int'($urandom_range(0, 4094)) - 2047;
               walk_angle = walk_angle + ANGLE_W'(jump);
            end
            item.raw_angle = walk_angle;
         end
         send_item(item);
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: 192 steps per turn.
      send_item(make_item(CMD_CONSUME, 12'hABC));
      send_item(make_item(CMD_SAMPLE, 4095));
      send_item(make_item(CMD_SAMPLE, 0));
      send_item(make_item(CMD_SAMPLE, 4095));
      send_item(make_item(CMD_SAMPLE, 2047));
      send_item(make_item(CMD_SAMPLE, 4095));
      send_item(make_item(CMD_SAMPLE, 2046));
      send_item(make_item(CMD_SAMPLE, 4095));
      send_item(make_item(CMD_CONSUME, 4095));
      send_item(make_item(CMD_CONSUME, 0));

      // Full scale of 1024 steps per turn gives the largest step counts.
      write_register(CSR_DETENT_COUNT, 8'd128);
      send_item(make_item(CMD_SAMPLE, 2047));
      send_item(make_item(CMD_SAMPLE, 4095));
      send_item(make_item(CMD_CONSUME, 1234));
      write_register(CSR_INVERT_DIRECTION, 8'hFF);
      send_item(make_item(CMD_SAMPLE, 2047));
      send_item(make_item(CMD_SAMPLE, 4095));
      send_item(make_item(CMD_SAMPLE, 4095));
      send_item(make_item(CMD_CONSUME, 0));
      walk_angle = 12'd4095;

      run_phase(8'd0, 1'b0, 220, 0, -1);
      run_phase(8'd255, 1'b1, 220, 160, -1);
      run_phase(8'd1, 1'b0, 220, 0, 40);
      run_phase(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 220, 0, -1);
      run_phase(8'($urandom_range(2, 127)), 1'b1, 220, 0, -1);

      drain_results();
      if (board.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
